// ----- rtl/slpw_pkg.sv -----
// Shared types, constants and helpers for the styled line pixel writer.
// Used by every module of the block but the checker; depends on nothing else.
package slpw_pkg;

  // Field widths
  localparam int COORD_W  = 12;
  localparam int ERR_W    = 14;
  localparam int POS_W    = 4;
  localparam int ADDR_W   = 15;
  localparam int MASK_W   = 8;
  localparam int STYLE_W  = 3;
  localparam int PAT_W    = 16;
  localparam int IN_TDATA_W  = 4 * COORD_W;
  localparam int OUT_TDATA_W = 32;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 4;

  // Default geometry of the framebuffer
  localparam int DEF_SCREEN_WIDTH  = 720;
  localparam int DEF_SCREEN_HEIGHT = 348;
  localparam int DEF_BYTES_PER_ROW = 90;
  localparam int DEF_BANK_SIZE     = 8192;

  // Request kinds on the input channel
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Line style codes
  localparam logic [STYLE_W-1:0] STYLE_SOLID  = 3'd0;
  localparam logic [STYLE_W-1:0] STYLE_DOTTED = 3'd1;
  localparam logic [STYLE_W-1:0] STYLE_CENTER = 3'd2;
  localparam logic [STYLE_W-1:0] STYLE_DASHED = 3'd3;
  localparam logic [STYLE_W-1:0] STYLE_USER   = 3'd4;

  // Preset dash patterns
  localparam logic [PAT_W-1:0] PAT_SOLID  = 16'hFFFF;
  localparam logic [PAT_W-1:0] PAT_DOTTED = 16'hCCCC;
  localparam logic [PAT_W-1:0] PAT_CENTER = 16'hF8F8;
  localparam logic [PAT_W-1:0] PAT_DASHED = 16'hF0F0;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_DASH_STYLE   = 2'd0;
  localparam logic [1:0] REG_USER_PATTERN = 2'd1;
  localparam logic [1:0] REG_DRAW_COLOR   = 2'd2;

  // Register reset values
  localparam logic [STYLE_W-1:0] RST_DASH_STYLE   = STYLE_SOLID;
  localparam logic [PAT_W-1:0]   RST_USER_PATTERN = 16'hFFFF;
  localparam logic               RST_DRAW_COLOR   = 1'b1;

  // Configuration seen by the pixel stage
  typedef struct packed {
    logic [STYLE_W-1:0] dash_style;
    logic [PAT_W-1:0]   user_pattern;
    logic               draw_color;
  } cfg_t;

  // One stepped point handed from the step stage to the pixel stage
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [POS_W-1:0]          pos;
    logic                      done;
    logic                      no_line;
  } point_t;

  // Pick the dash pattern for a style code
  function automatic logic [PAT_W-1:0] style_pattern(input logic [STYLE_W-1:0] style,
                                                     input logic [PAT_W-1:0]   user_pat);
    logic [PAT_W-1:0] pat;
    case (style)
      STYLE_DOTTED: pat = PAT_DOTTED;
      STYLE_CENTER: pat = PAT_CENTER;
      STYLE_DASHED: pat = PAT_DASHED;
      STYLE_USER:   pat = user_pat;
      default:      pat = PAT_SOLID;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/slpw_cfg.sv -----
// Configuration registers behind the APB-style port: line style, user
// dash pattern and draw color. Depends on slpw_pkg.
module slpw_cfg
  import slpw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  logic [STYLE_W-1:0] dash_style_r;
  logic [PAT_W-1:0]   user_pattern_r;
  logic               draw_color_r;
  logic [1:0]         reg_idx;
  logic               wr_en;

  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dash_style_r   <= RST_DASH_STYLE;
      user_pattern_r <= RST_USER_PATTERN;
      draw_color_r   <= RST_DRAW_COLOR;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DASH_STYLE:   dash_style_r   <= cfg_pwdata[STYLE_W-1:0];
        REG_USER_PATTERN: user_pattern_r <= cfg_pwdata[PAT_W-1:0];
        REG_DRAW_COLOR:   draw_color_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_DASH_STYLE:   cfg_prdata = APB_DATA_W'(dash_style_r);
      REG_USER_PATTERN: cfg_prdata = APB_DATA_W'(user_pattern_r);
      REG_DRAW_COLOR:   cfg_prdata = APB_DATA_W'(draw_color_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg.dash_style   = dash_style_r;
  assign cfg.user_pattern = user_pattern_r;
  assign cfg.draw_color   = draw_color_r;

endmodule

// ----- rtl/slpw_step.sv -----
// Bresenham step stage: holds the line state, takes one step per request
// and registers the resulting point. Depends on slpw_pkg.
module slpw_step
  import slpw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic signed [COORD_W-1:0] in_x_start,
  input  logic signed [COORD_W-1:0] in_y_start,
  input  logic signed [COORD_W-1:0] in_x_end,
  input  logic signed [COORD_W-1:0] in_y_end,
  output logic                      pt_valid,
  input  logic                      pt_ready,
  output point_t                    pt
);

  // Line state
  logic signed [COORD_W-1:0] cur_x_r, cur_x_nxt;
  logic signed [COORD_W-1:0] cur_y_r, cur_y_nxt;
  logic signed [COORD_W-1:0] end_x_r, end_x_nxt;
  logic signed [COORD_W-1:0] end_y_r, end_y_nxt;
  logic [COORD_W-1:0]        abs_dx_r, abs_dx_nxt;
  logic [COORD_W-1:0]        abs_dy_r, abs_dy_nxt;
  logic                      step_x_neg_r, step_x_neg_nxt;
  logic                      step_y_neg_r, step_y_neg_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic                      active_r, active_nxt;

  // Point register
  logic   pt_valid_r;
  point_t pt_r, pt_nxt;

  logic                      accept;
  logic signed [COORD_W:0]   dx_s, dy_s;
  logic [COORD_W-1:0]        adx, ady;
  logic signed [ERR_W:0]     e2;
  logic signed [ERR_W:0]     neg_dy;
  logic signed [ERR_W:0]     pos_dx;
  logic                      move_x, move_y;
  logic signed [ERR_W-1:0]   dx_term, dy_term;

  assign in_ready = !pt_valid_r || pt_ready;
  assign accept   = in_valid && in_ready;

  // Deltas of a new line
  assign dx_s = {in_x_end[COORD_W-1], in_x_end} - {in_x_start[COORD_W-1], in_x_start};
  assign dy_s = {in_y_end[COORD_W-1], in_y_end} - {in_y_start[COORD_W-1], in_y_start};
  assign adx  = dx_s[COORD_W] ? COORD_W'(-dx_s) : dx_s[COORD_W-1:0];
  assign ady  = dy_s[COORD_W] ? COORD_W'(-dy_s) : dy_s[COORD_W-1:0];

  // Step decision on the current error
  assign e2      = {err_r, 1'b0};
  assign neg_dy  = -$signed({{(ERR_W+1-COORD_W){1'b0}}, abs_dy_r});
  assign pos_dx  = $signed({{(ERR_W+1-COORD_W){1'b0}}, abs_dx_r});
  assign move_x  = e2 > neg_dy;
  assign move_y  = e2 < pos_dx;
  assign dy_term = move_y ? $signed({{(ERR_W-COORD_W){1'b0}}, abs_dx_r}) : '0;
  assign dx_term = move_x ? $signed({{(ERR_W-COORD_W){1'b0}}, abs_dy_r}) : '0;

  // Next state and emitted point
  always_comb begin
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    end_x_nxt      = end_x_r;
    end_y_nxt      = end_y_r;
    abs_dx_nxt     = abs_dx_r;
    abs_dy_nxt     = abs_dy_r;
    step_x_neg_nxt = step_x_neg_r;
    step_y_neg_nxt = step_y_neg_r;
    err_nxt        = err_r;
    pos_nxt        = pos_r;
    active_nxt     = active_r;
    pt_nxt         = '0;
    if (in_op == OP_START) begin
      cur_x_nxt      = in_x_start;
      cur_y_nxt      = in_y_start;
      end_x_nxt      = in_x_end;
      end_y_nxt      = in_y_end;
      abs_dx_nxt     = adx;
      abs_dy_nxt     = ady;
      step_x_neg_nxt = !(in_x_start < in_x_end);
      step_y_neg_nxt = !(in_y_start < in_y_end);
      err_nxt        = $signed({{(ERR_W-COORD_W){1'b0}}, adx})
                     - $signed({{(ERR_W-COORD_W){1'b0}}, ady});
      pos_nxt        = '0;
      pt_nxt.done    = (in_x_start == in_x_end) && (in_y_start == in_y_end);
      active_nxt     = !pt_nxt.done;
      pt_nxt.x       = in_x_start;
      pt_nxt.y       = in_y_start;
      pt_nxt.pos     = '0;
    end else if (!active_r) begin
      // Advance without a line: flag it and leave the state alone
      pt_nxt.no_line = 1'b1;
    end else begin
      if (move_x) begin
        cur_x_nxt = step_x_neg_r ? cur_x_r - COORD_W'(1) : cur_x_r + COORD_W'(1);
      end
      if (move_y) begin
        cur_y_nxt = step_y_neg_r ? cur_y_r - COORD_W'(1) : cur_y_r + COORD_W'(1);
      end
      err_nxt     = err_r - dx_term + dy_term;
      pos_nxt     = pos_r + POS_W'(1);
      pt_nxt.done = (cur_x_nxt == end_x_r) && (cur_y_nxt == end_y_r);
      active_nxt  = !pt_nxt.done;
      pt_nxt.x    = cur_x_nxt;
      pt_nxt.y    = cur_y_nxt;
      pt_nxt.pos  = pos_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      pt_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        pt_valid_r <= in_valid;
      end
      if (accept) begin
        active_r <= active_nxt;
      end
    end
  end

  // Line state and point payload advance on each accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      end_x_r      <= end_x_nxt;
      end_y_r      <= end_y_nxt;
      abs_dx_r     <= abs_dx_nxt;
      abs_dy_r     <= abs_dy_nxt;
      step_x_neg_r <= step_x_neg_nxt;
      step_y_neg_r <= step_y_neg_nxt;
      err_r        <= err_nxt;
      pos_r        <= pos_nxt;
      pt_r         <= pt_nxt;
    end
  end

  assign pt_valid = pt_valid_r;
  assign pt       = pt_r;

endmodule

// ----- rtl/slpw_pixel.sv -----
// Pixel stage: dash pattern test, screen clipping, banked byte address and
// bit mask, held in the result register. Depends on slpw_pkg.
module slpw_pixel
  import slpw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int BYTES_PER_ROW = DEF_BYTES_PER_ROW,
  parameter int BANK_SIZE     = DEF_BANK_SIZE
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pt_valid,
  output logic                   pt_ready,
  input  point_t                 pt,
  input  cfg_t                   cfg,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  localparam logic [COORD_W-1:0] WIDTH_LIM  = COORD_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0] HEIGHT_LIM = COORD_W'(SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0]  BANK_C     = ADDR_W'(BANK_SIZE);
  localparam logic [ADDR_W-1:0]  ROW_C      = ADDR_W'(BYTES_PER_ROW);

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] tdata_r, tdata_nxt;
  logic                   tlast_r;
  logic                   tuser_r;

  logic [PAT_W-1:0]  pat;
  logic              on_screen;
  logic              wr_en;
  logic [ADDR_W-1:0] addr;
  logic [MASK_W-1:0] mask;

  assign pt_ready = !out_valid_r || out_tready;

  // Pattern bit and clipping
  assign pat       = style_pattern(cfg.dash_style, cfg.user_pattern);
  assign on_screen = !pt.x[COORD_W-1] && ($unsigned(pt.x) < WIDTH_LIM)
                  && !pt.y[COORD_W-1] && ($unsigned(pt.y) < HEIGHT_LIM);
  assign wr_en     = pat[pt.pos] && on_screen && !pt.no_line;

  // Banked address, wraps at the address width
  assign addr = ADDR_W'(pt.y[1:0]) * BANK_C
              + ADDR_W'(pt.y[COORD_W-1:2]) * ROW_C
              + ADDR_W'(pt.x[COORD_W-1:3]);
  assign mask = MASK_W'(8'h80 >> pt.x[2:0]);

  // Zero the write fields when nothing is written
  always_comb begin
    tdata_nxt = '0;
    if (wr_en) begin
      tdata_nxt[0]                     = 1'b1;
      tdata_nxt[ADDR_W:1]              = addr;
      tdata_nxt[ADDR_W+MASK_W:ADDR_W+1] = mask;
      tdata_nxt[ADDR_W+MASK_W+1]       = cfg.draw_color;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pt_ready) begin
      out_valid_r <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_valid && pt_ready) begin
      tdata_r <= tdata_nxt;
      tlast_r <= pt.done;
      tuser_r <= pt.no_line;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tdata_r;
  assign out_tlast  = tlast_r;
  assign out_tuser  = tuser_r;

endmodule

// ----- rtl/styled_line_pixel_writer.sv -----
// Styled line pixel writer: takes a start or advance request per cycle and
// returns one framebuffer write per request, held first in the point
// register, then in the result register, and sustains one request per
// clock while the result channel does not stall; the rate is set by the
// Bresenham state update, which is formed combinationally so that the next
// step can follow at once. A start request loads both endpoints and returns
// the first point; each advance returns the next point, with tlast on the
// second endpoint. Points off screen or on a gap of the dash pattern come
// back with write_enable low and zero address, mask and value; an advance
// with no line in progress comes back with tuser high and all else zero.
// The memory is expected to do the read-modify-write with the given mask.
// Depends on slpw_pkg, slpw_cfg, slpw_step and slpw_pixel.
module styled_line_pixel_writer
  import slpw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int BYTES_PER_ROW = DEF_BYTES_PER_ROW,
  parameter int BANK_SIZE     = DEF_BANK_SIZE
)(
  input  logic                   clk,
  input  logic                   rst_n,
  // Request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata: x_start[11:0], y_start[23:12], x_end[35:24], y_end[47:36]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: op[0]
  input  logic                   in_tuser,
  // Result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: write_enable[0], byte_address[15:1], bit_mask[23:16],
  //        bit_value[24], zero[31:25]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // tlast: line_done
  output logic                   out_tlast,
  // tuser: no_line[0]
  output logic                   out_tuser,
  // Configuration port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [APB_DATA_W-1:0]  cfg_pwdata,
  output logic [APB_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t   cfg;
  point_t pt;
  logic   pt_valid;
  logic   pt_ready;

  // Configuration registers
  slpw_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Line stepping
  slpw_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_x_start ($signed(in_tdata[COORD_W-1:0])),
    .in_y_start ($signed(in_tdata[2*COORD_W-1:COORD_W])),
    .in_x_end   ($signed(in_tdata[3*COORD_W-1:2*COORD_W])),
    .in_y_end   ($signed(in_tdata[4*COORD_W-1:3*COORD_W])),
    .pt_valid   (pt_valid),
    .pt_ready   (pt_ready),
    .pt         (pt)
  );

  // Pixel address and result register
  slpw_pixel #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .BANK_SIZE     (BANK_SIZE)
  ) u_pixel (
    .clk        (clk),
    .rst_n      (rst_n),
    .pt_valid   (pt_valid),
    .pt_ready   (pt_ready),
    .pt         (pt),
    .cfg        (cfg),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- rtl/slpw_checker.sv -----
// Port-level checks for the styled line pixel writer, bound to the top
// level. Depends only on the top level's ports.
module slpw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // An advance without a line carries nothing else
  a_no_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0 && !out_tlast)
    else $error("empty result carries data");

  // No write means zero address, mask and value
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[31:1] == 31'd0)
    else $error("suppressed write carries fields");

  // A write has exactly one mask bit
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> $onehot(out_tdata[23:16]) && out_tdata[31:25] == 7'd0)
    else $error("bad write mask");

endmodule

bind styled_line_pixel_writer slpw_checker u_slpw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ----- bench/tb_styled_line_pixel_writer.sv -----
// Self-checking bench for styled_line_pixel_writer: directed rows, then random line
// sequences under nine register settings, checked against a Bresenham predictor.
// Depends on slpw_pkg and the styled_line_pixel_writer RTL only.
`timescale 1ns / 100ps

module tb_styled_line_pixel_writer;
  import slpw_pkg::*;

  localparam int SCR_W       = DEF_SCREEN_WIDTH;
  localparam int SCR_H       = DEF_SCREEN_HEIGHT;
  localparam int ROW_BYTES   = DEF_BYTES_PER_ROW;
  localparam int BANK_BYTES  = DEF_BANK_SIZE;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 9;
  localparam int PHASE_REQS  = 205;

  // Style codes past the named ones; the block treats them as solid
  localparam logic [STYLE_W-1:0] STYLE_SPARE_LO = 3'd5;
  localparam logic [STYLE_W-1:0] STYLE_SPARE_HI = 3'd7;

  // One framebuffer write as the block returns it
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [MASK_W-1:0] mask;
    logic              val;
    logic              done;
    logic              no_line;
  } pixel_write_t;

  localparam pixel_write_t NO_LINE_W = {1'b0, 15'd0, 8'd0, 1'b0, 1'b0, 1'b1};

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] xe;
    logic signed [COORD_W-1:0] ye;
    logic                      typed;
    pixel_write_t              want;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [APB_ADDR_W-1:0]  cfg_paddr;
  logic [APB_DATA_W-1:0]  cfg_pwdata;
  logic [APB_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // Predictor copy of the line state and the registers
  logic signed [COORD_W-1:0] ln_x, ln_y, ln_end_x, ln_end_y;
  logic [COORD_W-1:0]        ln_adx, ln_ady;
  logic                      ln_xneg, ln_yneg;
  logic signed [ERR_W-1:0]   ln_err;
  logic [POS_W-1:0]          ln_pos;
  logic                      ln_active;
  logic [STYLE_W-1:0]        sh_style;
  logic [PAT_W-1:0]          sh_pattern;
  logic                      sh_color;

  pixel_write_t pixel_writes_due[$];
  pixel_write_t due_w;
  dir_row_t     dir_rows[$];

  int snd_idle_pct, rcv_idle_pct;
  int n_req, n_results, n_writes, n_done, n_noline, n_err;
  int stall_cycles;

  styled_line_pixel_writer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    n_err++;
  endtask

  // Advance the line by one request and form the write it produces
  function automatic pixel_write_t next_pixel_write(input logic op,
                                                    input logic [IN_TDATA_W-1:0] data);
    pixel_write_t      w;
    logic [PAT_W-1:0]  pat;
    logic [COORD_W-1:0] ux, uy;
    int dx, dy, err, e2;
    w = '0;
    if (op == OP_START) begin
      ln_x     = data[11:0];
      ln_y     = data[23:12];
      ln_end_x = data[35:24];
      ln_end_y = data[47:36];
      dx = ln_end_x - ln_x;
      dy = ln_end_y - ln_y;
      ln_adx  = COORD_W'((dx < 0) ? -dx : dx);
      ln_ady  = COORD_W'((dy < 0) ? -dy : dy);
      ln_xneg = !(ln_x < ln_end_x);
      ln_yneg = !(ln_y < ln_end_y);
      ln_err  = ERR_W'(int'(ln_adx) - int'(ln_ady));
      ln_pos  = '0;
      ln_active = 1'b1;
    end else if (!ln_active) begin
      return NO_LINE_W;
    end else begin
      // one Bresenham step
      err = ln_err;
      e2  = 2 * err;
      if (e2 > -int'(ln_ady)) begin
        err  = err - int'(ln_ady);
        ln_x = COORD_W'(ln_x + (ln_xneg ? -1 : 1));
      end
      if (e2 < int'(ln_adx)) begin
        err  = err + int'(ln_adx);
        ln_y = COORD_W'(ln_y + (ln_yneg ? -1 : 1));
      end
      ln_err = ERR_W'(err);
      ln_pos = ln_pos + 1'b1;
    end

    case (sh_style)
      STYLE_DOTTED: pat = PAT_DOTTED;
      STYLE_CENTER: pat = PAT_CENTER;
      STYLE_DASHED: pat = PAT_DASHED;
      STYLE_USER:   pat = sh_pattern;
      default:      pat = PAT_SOLID;
    endcase

    w.done = (ln_x == ln_end_x) && (ln_y == ln_end_y);
    // clip to the screen, then map into the four interleaved banks
    if (pat[ln_pos] && ln_x >= 0 && int'(ln_x) < SCR_W && ln_y >= 0 && int'(ln_y) < SCR_H) begin
      ux = ln_x;
      uy = ln_y;
      w.we   = 1'b1;
      w.addr = ADDR_W'(int'(uy[1:0]) * BANK_BYTES + int'(uy[11:2]) * ROW_BYTES
                       + int'(ux[11:3]));
      w.mask = 8'h80 >> ux[2:0];
      w.val  = sh_color;
    end
    if (w.done) ln_active = 1'b0;
    return w;
  endfunction

  function automatic void add_row(input logic op, input int xs, input int ys, input int xe,
                                  input int ye, input logic typed, input pixel_write_t want);
    dir_row_t r;
    r.op = op;
    r.xs = COORD_W'(xs);
    r.ys = COORD_W'(ys);
    r.xe = COORD_W'(xe);
    r.ye = COORD_W'(ye);
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  // Offer one request, hold it until accepted, queue the write it must produce
  task automatic send_req(input logic op, input logic [IN_TDATA_W-1:0] data,
                          input logic typed, input pixel_write_t want);
    pixel_write_t w;
    while (snd_idle_pct > 0 && $urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    w = next_pixel_write(op, data);
    pixel_writes_due.push_back(typed ? want : w);
    n_req++;
  endtask

  // Drop valid and wait until every queued write has come back
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pixel_writes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic set_register(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] keep;
    case (idx)
      REG_DASH_STYLE: begin
        keep = 32'h7;
        sh_style = value[STYLE_W-1:0];
      end
      REG_USER_PATTERN: begin
        keep = 32'hFFFF;
        sh_pattern = value[PAT_W-1:0];
      end
      default: begin
        keep = 32'h1;
        sh_color = value[0];
      end
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if ((cfg_prdata & keep) != (value & keep))
      report_mismatch($sformatf("readback of register %0d", idx), cfg_prdata & keep,
                      value & keep);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random line sequences until the request count reaches stop_at
  task automatic run_lines(input int stop_at);
    logic signed [COORD_W-1:0] xs, ys, xe, ye;
    logic [IN_TDATA_W-1:0] junk;
    logic has_start;
    int k, span, dx, dy, steps, tail;
    while (n_req < stop_at) begin
      k = $urandom_range(0, 99);
      has_start = 1'b1;
      tail = 0;
      if (k < 65) begin
        // short line near the screen, mostly run to its end
        span = ($urandom_range(0, 7) == 0) ? 64 : 12;
        xs = COORD_W'(int'($urandom_range(0, SCR_W + 15)) - 8);
        ys = COORD_W'(int'($urandom_range(0, SCR_H + 15)) - 8);
        dx = int'($urandom_range(0, 2 * span)) - span;
        dy = int'($urandom_range(0, 2 * span)) - span;
        xe = COORD_W'(xs + dx);
        ye = COORD_W'(ys + dy);
        steps = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                          : (dy < 0 ? -dy : dy);
        if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
        if ($urandom_range(0, 3) == 0) tail = $urandom_range(1, 2);
      end else if (k < 85) begin
        // full-range endpoints, abandoned after a few steps
        xs = COORD_W'($urandom);
        ys = COORD_W'($urandom);
        xe = COORD_W'($urandom);
        ye = COORD_W'($urandom);
        steps = $urandom_range(0, 8);
      end else if (k < 93) begin
        // single-point line
        if ($urandom_range(0, 1) == 1) begin
          xs = COORD_W'($urandom);
          ys = COORD_W'($urandom);
        end else begin
          xs = COORD_W'($urandom_range(0, SCR_W - 1));
          ys = COORD_W'($urandom_range(0, SCR_H - 1));
        end
        xe = xs;
        ye = ys;
        steps = 0;
        tail = $urandom_range(0, 1);
      end else begin
        // stray advances
        has_start = 1'b0;
        steps = 0;
        tail = $urandom_range(1, 3);
      end
      if (has_start) send_req(OP_START, {ye, xe, ys, xs}, 1'b0, '0);
      repeat (steps + tail) begin
        junk = IN_TDATA_W'({$urandom, $urandom});
        send_req(OP_ADVANCE, junk, 1'b0, '0);
      end
    end
  endtask

  // Accept results, compare with the oldest queued write, drive the stall pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pixel_writes_due.size() == 0) begin
        report_mismatch("result with nothing queued", out_tdata, 0);
      end else begin
        due_w = pixel_writes_due.pop_front();
        if (out_tdata[0] !== due_w.we)
          report_mismatch("write_enable", int'(out_tdata[0]), int'(due_w.we));
        if (out_tdata[15:1] !== due_w.addr)
          report_mismatch("byte_address", int'(out_tdata[15:1]), int'(due_w.addr));
        if (out_tdata[23:16] !== due_w.mask)
          report_mismatch("bit_mask", int'(out_tdata[23:16]), int'(due_w.mask));
        if (out_tdata[24] !== due_w.val)
          report_mismatch("bit_value", int'(out_tdata[24]), int'(due_w.val));
        if (out_tlast !== due_w.done)
          report_mismatch("line_done", int'(out_tlast), int'(due_w.done));
        if (out_tuser !== due_w.no_line)
          report_mismatch("no_line", int'(out_tuser), int'(due_w.no_line));
      end
      if (out_tdata[0]) n_writes++;
      if (out_tlast) n_done++;
      if (out_tuser) n_noline++;
    end
    out_tready <= (rcv_idle_pct == 0) || ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Watchdog on cycles with no request and no result moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] no traffic for %0d cycles, %0d writes still due", $time, STALL_LIMIT,
               pixel_writes_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [STYLE_W-1:0] phase_style[PHASES];
    logic [PAT_W-1:0]   pat;
    int p;
    phase_style = '{STYLE_DOTTED, STYLE_CENTER, STYLE_DASHED, STYLE_USER, STYLE_USER,
                    STYLE_USER, STYLE_SPARE_HI, STYLE_SPARE_LO, STYLE_SOLID};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_START;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    n_req = 0;
    n_results = 0;
    n_writes = 0;
    n_done = 0;
    n_noline = 0;
    n_err = 0;
    stall_cycles = 0;
    snd_idle_pct = 15;
    rcv_idle_pct = 49;
    ln_x = '0;
    ln_y = '0;
    ln_end_x = '0;
    ln_end_y = '0;
    ln_adx = '0;
    ln_ady = '0;
    ln_xneg = 1'b0;
    ln_yneg = 1'b0;
    ln_err = '0;
    ln_pos = '0;
    ln_active = 1'b0;
    sh_style = RST_DASH_STYLE;
    sh_pattern = RST_USER_PATTERN;
    sh_color = RST_DRAW_COLOR;

    // Directed rows: reset, screen corners, clipping, single points, both step directions,
    // restart during a line
    add_row(OP_ADVANCE, 0, 0, 0, 0, 1'b1, NO_LINE_W);
    add_row(OP_START, 0, 0, 0, 0, 1'b1, {1'b1, 15'd0, 8'h80, 1'b1, 1'b1, 1'b0});
    add_row(OP_ADVANCE, 0, 0, 0, 0, 1'b1, NO_LINE_W);
    add_row(OP_START, 719, 347, 719, 347, 1'b1, {1'b1, 15'd32405, 8'h01, 1'b1, 1'b1, 1'b0});
    add_row(OP_START, -2048, -2048, 2047, 2047, 1'b1, '0);
    add_row(OP_ADVANCE, 0, 0, 0, 0, 1'b0, '0);
    add_row(OP_START, 720, 0, 720, 5, 1'b1, '0);
    add_row(OP_START, 0, 348, 3, 348, 1'b1, '0);
    add_row(OP_START, 716, 344, 719, 347, 1'b0, '0);
    repeat (3) add_row(OP_ADVANCE, 0, 0, 0, 0, 1'b0, '0);
    add_row(OP_ADVANCE, 0, 0, 0, 0, 1'b1, NO_LINE_W);
    add_row(OP_START, 5, 5, 3, 9, 1'b0, '0);
    repeat (4) add_row(OP_ADVANCE, 0, 0, 0, 0, 1'b0, '0);
    add_row(OP_START, 100, 100, 200, 150, 1'b0, '0);
    repeat (2) add_row(OP_ADVANCE, 0, 0, 0, 0, 1'b0, '0);
    add_row(OP_START, 2047, -2048, -2048, 2047, 1'b1, '0);
    add_row(OP_ADVANCE, 0, 0, 0, 0, 1'b0, '0);
    add_row(OP_START, -1, -1, 1, 1, 1'b1, '0);
    add_row(OP_ADVANCE, 0, 0, 0, 0, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_req(dir_rows[i].op,
               {dir_rows[i].ye, dir_rows[i].xe, dir_rows[i].ys, dir_rows[i].xs},
               dir_rows[i].typed, dir_rows[i].want);
    drain();

    // Random phases: each gets its own register setting; lines may span phases
    for (p = 0; p < PHASES; p++) begin
      snd_idle_pct = (p < 3) ? 15 : (p < 6) ? 49 : 0;
      rcv_idle_pct = (p < 3) ? 49 : (p < 6) ? 15 : 0;
      pat = (p == 3) ? 16'h0000 : (p == 4) ? 16'hFFFF : PAT_W'($urandom);
      set_register(REG_DASH_STYLE, 32'(phase_style[p]));
      set_register(REG_USER_PATTERN, 32'(pat));
      set_register(REG_DRAW_COLOR, 32'((p % 3) != 1));
      run_lines(n_req + PHASE_REQS);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("%0d requests, %0d results: %0d pixel writes, %0d line ends, %0d stray advances",
             n_req, n_results, n_writes, n_done, n_noline);
    $display("%0d register settings: all styles, both colors, empty and full user pattern",
             PHASES);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_err);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/slpw_pkg.sv
rtl/slpw_cfg.sv
rtl/slpw_step.sv
rtl/slpw_pixel.sv
rtl/styled_line_pixel_writer.sv
rtl/slpw_checker.sv
bench/tb_styled_line_pixel_writer.sv
